@@ hw/rtl/top_k_weight_selector_macros.svh @@
// Assertion macros shared by the top-K weight selector RTL.
`ifndef TOP_K_WEIGHT_SELECTOR_MACROS_SVH
`define TOP_K_WEIGHT_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define TKWS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("top_k_weight_selector: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define TKWS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("top_k_weight_selector: next-cycle check failed");
`else
`define TKWS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TKWS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/tkws_pkg.sv @@
// Package: widths, defaults and controller/datapath interface types.
`timescale 1ns / 1ps
package tkws_pkg;

  localparam int unsigned WEIGHT_W      = 48;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned RANK_W        = 6;
  localparam int unsigned TOP_COUNT_DEF = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic insert;  // place the incoming candidate into the sorted cells
    logic shift;   // pop cell 0, move every cell up by one
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_entry;  // cell 0 holds the final kept entry
  } stat_t;

endpackage

@@ hw/rtl/tkws_datapath.sv @@
// Datapath: row of compare-and-insert cells holding the sorted top-K entries.
`timescale 1ns / 1ps
`include "top_k_weight_selector_macros.svh"
module tkws_datapath #(
  parameter int unsigned TOP_COUNT = tkws_pkg::TOP_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tkws_pkg::cmd_t                cmd_i,
  input  logic [tkws_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [tkws_pkg::TAG_W-1:0]    tag_i,
  output tkws_pkg::stat_t               stat_o,
  output logic [tkws_pkg::WEIGHT_W-1:0] out_weight_o,
  output logic [tkws_pkg::TAG_W-1:0]    out_tag_o
);

  localparam logic [TOP_COUNT-1:0] VldOne = TOP_COUNT'(1);

  logic [TOP_COUNT-1:0] valid_q, valid_d, ins, vld_inc, sort_ok;
  logic [TOP_COUNT:0]   ins_ext, vld_ext;

  logic [tkws_pkg::WEIGHT_W-1:0] kw_q [TOP_COUNT];
  logic [tkws_pkg::WEIGHT_W-1:0] kw_d [TOP_COUNT];
  logic [tkws_pkg::WEIGHT_W-1:0] prev_w [TOP_COUNT];
  logic [tkws_pkg::WEIGHT_W-1:0] next_w [TOP_COUNT];
  logic [tkws_pkg::TAG_W-1:0]    kt_q [TOP_COUNT];
  logic [tkws_pkg::TAG_W-1:0]    kt_d [TOP_COUNT];
  logic [tkws_pkg::TAG_W-1:0]    prev_t [TOP_COUNT];
  logic [tkws_pkg::TAG_W-1:0]    next_t [TOP_COUNT];
  logic [TOP_COUNT-1:0]          prev_v;

  // ins_ext[i] = cell i-1 takes the new item or shifts, so cell i shifts down
  assign ins_ext = {ins, 1'b0};
  assign vld_ext = {1'b0, valid_q};

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    // strictly greater moves ahead; equal weights keep arrival order
    assign ins[i] = !valid_q[i] || (weight_i > kw_q[i]);

    if (i == 0) begin : g_head
      assign prev_w[i] = weight_i;
      assign prev_t[i] = tag_i;
      assign prev_v[i] = 1'b0;
    end else begin : g_body
      assign prev_w[i] = kw_q[i-1];
      assign prev_t[i] = kt_q[i-1];
      assign prev_v[i] = valid_q[i-1];
    end

    if (i == TOP_COUNT - 1) begin : g_tail
      assign next_w[i]  = kw_q[i];
      assign next_t[i]  = kt_q[i];
      assign sort_ok[i] = 1'b1;
    end else begin : g_mid
      assign next_w[i]  = kw_q[i+1];
      assign next_t[i]  = kt_q[i+1];
      assign sort_ok[i] = !valid_q[i+1] || (kw_q[i] >= kw_q[i+1]);
    end

    always_comb begin
      kw_d[i]    = kw_q[i];
      kt_d[i]    = kt_q[i];
      valid_d[i] = valid_q[i];
      if (cmd_i.insert) begin
        if (ins_ext[i]) begin
          kw_d[i]    = prev_w[i];
          kt_d[i]    = prev_t[i];
          valid_d[i] = prev_v[i];
        end else if (ins[i]) begin
          kw_d[i]    = weight_i;
          kt_d[i]    = tag_i;
          valid_d[i] = 1'b1;
        end
      end else if (cmd_i.shift) begin
        kw_d[i]    = next_w[i];
        kt_d[i]    = next_t[i];
        valid_d[i] = vld_ext[i+1];
      end
    end

    always_ff @(posedge clk_i) begin
      kw_q[i] <= kw_d[i];
      kt_q[i] <= kt_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stat_o.last_entry = !vld_ext[1];
  assign out_weight_o      = kw_q[0];
  assign out_tag_o         = kt_q[0];

  // valid cells always form a run from cell 0
  assign vld_inc = valid_q + VldOne;

  `TKWS_ASSERT_IMP(a_shift_has_entry, clk_i, rst_ni, cmd_i.shift, valid_q[0])
  `TKWS_ASSERT_IMP(a_valid_packed, clk_i, rst_ni, 1'b1, $onehot0(vld_inc))
  `TKWS_ASSERT_IMP(a_cells_sorted, clk_i, rst_ni, 1'b1, &sort_ok)

endmodule

@@ hw/rtl/tkws_ctrl.sv @@
// Controller: accepts candidates and sequences the ranked readout.
`timescale 1ns / 1ps
`include "top_k_weight_selector_macros.svh"
module tkws_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        final_item_i,
  input  tkws_pkg::stat_t             stat_i,
  output tkws_pkg::cmd_t              cmd_o,
  output logic                        busy_o,
  output logic                        result_valid_o,
  output logic [tkws_pkg::RANK_W-1:0] rank_o
);

  localparam logic [tkws_pkg::RANK_W-1:0] RankOne = tkws_pkg::RANK_W'(1);

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e                      state_q;
  logic [tkws_pkg::RANK_W-1:0] rank_q;

  assign cmd_o.insert   = (state_q == StIdle) && start_i;
  assign cmd_o.shift    = (state_q == StEmit);
  assign busy_o         = (state_q == StEmit);
  assign result_valid_o = (state_q == StEmit);
  assign rank_o         = rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rank_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i && final_item_i) begin
            state_q <= StEmit;
            rank_q  <= '0;
          end
        end
        StEmit: begin
          rank_q <= rank_q + RankOne;
          if (stat_i.last_entry) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `TKWS_ASSERT_NXT(a_final_starts_emit, clk_i, rst_ni, cmd_o.insert && final_item_i, busy_o)
  `TKWS_ASSERT_NXT(a_emit_holds, clk_i, rst_ni, busy_o && !stat_i.last_entry, busy_o)
  `TKWS_ASSERT_IMP(a_no_insert_busy, clk_i, rst_ni, busy_o, !cmd_o.insert)

endmodule

@@ hw/rtl/top_k_weight_selector.sv @@
// Top level: stable top-K selection of (weight, tag) candidates.
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------------
//  in      | start_i, busy_o          | weight_i, tag_i, final_item_i
//  out     | result_valid_o (strobe)  | out_weight_o, out_tag_o, rank_o, last_result_o
//
// An input transaction completes on a rising edge with start_i high and busy_o low.
// A non-final candidate is inserted into the sorted cells on that same edge, so
// candidates may stream at one per cycle while busy_o is low. A final candidate is inserted the same way,
// then busy_o stays high while the N kept entries (1..TOP_COUNT) are popped from cell 0,
// one result transaction per cycle. Results cannot be stalled. Reset empties the store
// (valid bits only).
`timescale 1ns / 1ps
module top_k_weight_selector #(
  parameter int unsigned TOP_COUNT = tkws_pkg::TOP_COUNT_DEF  // kept entries, 1..64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // candidate transactions
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tkws_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [tkws_pkg::TAG_W-1:0]    tag_i,
  input  logic                          final_item_i,
  // ranked result transactions
  output logic                          result_valid_o,
  output logic [tkws_pkg::WEIGHT_W-1:0] out_weight_o,
  output logic [tkws_pkg::TAG_W-1:0]    out_tag_o,
  output logic [tkws_pkg::RANK_W-1:0]   rank_o,
  output logic                          last_result_o
);

  tkws_pkg::cmd_t  cmd;
  tkws_pkg::stat_t stat;

  // Sequencer: idle/accept vs. readout, owns the rank counter
  tkws_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .final_item_i   (final_item_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .rank_o         (rank_o)
  );

  // Sorted cell row: parallel compares place each candidate on the edge that accepts it,
  // and the readout pops the heaviest entry from cell 0.
  tkws_datapath #(
    .TOP_COUNT (TOP_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .weight_i     (weight_i),
    .tag_i        (tag_i),
    .stat_o       (stat),
    .out_weight_o (out_weight_o),
    .out_tag_o    (out_tag_o)
  );

  // cell 1 empty while popping cell 0 means this is the final result of the set
  assign last_result_o = stat.last_entry;

endmodule
